FILE: hw/rtl/bgai_pkg.sv
// Shared types and constants of the battery gauge.
`default_nettype none
package bgai_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int PCT_W      = 7;
  localparam int NUM_BREAKS = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_W      = SAMPLE_W + 5;

  localparam logic [PCT_W-1:0] STEP_PCT = 7'd20;
  localparam logic [PCT_W-1:0] PCT_ZERO = 7'd0;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  localparam logic [SAMPLE_W-1:0] MEAN_RESET = 12'd0;

  typedef logic [SAMPLE_W-1:0] brk_arr_t [NUM_BREAKS];

  localparam brk_arr_t BREAK_RESET = '{
    12'd1970, 12'd2062, 12'd2154, 12'd2246, 12'd2338, 12'd2430
  };

  typedef struct packed {
    logic load;
    logic sum_run;
    logic div_start_mean;
    logic div_run;
    logic commit_mean;
    logic map_run;
    logic commit_pct;
    logic out_load;
  } bgai_cmd_t;

  typedef struct packed {
    logic sum_done;
    logic div_done;
    logic need_div;
  } bgai_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/bgai_ctrl.sv
// Sequencing controller of the battery gauge.
`default_nettype none
module bgai_ctrl
  import bgai_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_sample_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire bgai_sts_t sts,
  output bgai_cmd_t      cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SUM  = 6'b000010,
    ST_DIVM = 6'b000100,
    ST_MAP  = 6'b001000,
    ST_DIVP = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = in_sample_valid ? ST_SUM : ST_OUT;
        end
      end
      ST_SUM: begin
        cmd.sum_run = 1'b1;
        if (sts.sum_done) begin
          cmd.div_start_mean = 1'b1;
          state_nxt          = ST_DIVM;
        end
      end
      ST_DIVM: begin
        cmd.div_run = 1'b1;
        if (sts.div_done) begin
          cmd.commit_mean = 1'b1;
          state_nxt       = ST_MAP;
        end
      end
      ST_MAP: begin
        cmd.map_run = 1'b1;
        state_nxt   = sts.need_div ? ST_DIVP : ST_OUT;
      end
      ST_DIVP: begin
        cmd.div_run = 1'b1;
        if (sts.div_done) begin
          cmd.commit_pct = 1'b1;
          state_nxt      = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/bgai_dp.sv
// Datapath of the battery gauge: history ring, sum, shared divider, mapping.
`default_nettype none
module bgai_dp
  import bgai_pkg::*;
#(
  parameter int HISTORY_DEPTH = 3
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire bgai_cmd_t             cmd,
  output bgai_sts_t                  sts,
  input  wire logic [SAMPLE_W-1:0]   in_sample,
  input  wire logic                  in_sample_valid,
  input  wire logic                  in_charge_pin,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [SAMPLE_W-1:0]   cfg_wdata,
  output logic [PCT_W-1:0]           out_percent,
  output logic [SAMPLE_W-1:0]        out_mean_sample,
  output logic                       out_charging
);

  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W = SAMPLE_W + CNT_W;
  localparam int DIV_W = (SUM_W > NUM_W) ? SUM_W : NUM_W;
  localparam int DVS_W = SAMPLE_W;
  localparam int DC_W  = $clog2(DIV_W + 1);

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(HISTORY_DEPTH);

  // Breakpoint registers
  logic [SAMPLE_W-1:0] brk_r [NUM_BREAKS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brk_r <= BREAK_RESET;
    end else begin
      for (int i = 0; i < NUM_BREAKS; i++) begin
        if (cfg_we && (cfg_index == CFG_IDX_W'(i))) begin
          brk_r[i] <= cfg_wdata;
        end
      end
    end
  end

  // History ring
  logic [SAMPLE_W-1:0] ring_mem [HISTORY_DEPTH];
  logic [IDX_W-1:0]    wr_slot_r;
  logic [CNT_W-1:0]    fill_r;
  logic [CNT_W-1:0]    rd_idx_r;
  logic                rd_vld_r;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic [SUM_W-1:0]    sum_r;
  logic                ring_wr;
  logic                rd_issue;

  assign ring_wr  = cmd.load && in_sample_valid;
  assign rd_issue = cmd.sum_run && (rd_idx_r != fill_r);

  always_ff @(posedge clk) begin
    if (ring_wr) begin
      ring_mem[wr_slot_r] <= in_sample;
    end
    if (rd_issue) begin
      rd_data_r <= ring_mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_slot_r <= '0;
      fill_r    <= '0;
      rd_idx_r  <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (ring_wr) begin
        wr_slot_r <= (wr_slot_r == LAST_SLOT) ? '0 : wr_slot_r + 1'b1;
        if (fill_r != FULL_CNT) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (cmd.load) begin
        rd_idx_r <= '0;
        rd_vld_r <= 1'b0;
      end else begin
        rd_vld_r <= rd_issue;
        if (rd_issue) begin
          rd_idx_r <= rd_idx_r + 1'b1;
        end
      end
    end
  end

  // Accumulate one entry per cycle, in the cycle after its read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sum_r <= '0;
    end else if (rd_vld_r) begin
      sum_r <= sum_r + SUM_W'(rd_data_r);
    end
  end

  assign sts.sum_done = (rd_idx_r == fill_r) && !rd_vld_r;

  // Segment search over the current mean
  logic [SAMPLE_W-1:0] last_mean_r;
  logic [PCT_W-1:0]    last_pct_r;
  logic                seg_hit;
  logic [PCT_W-1:0]    seg_base;
  logic [SAMPLE_W-1:0] seg_lo;
  logic [SAMPLE_W-1:0] seg_hi;
  logic [SAMPLE_W-1:0] seg_diff;
  logic [NUM_W-1:0]    seg_num;
  logic [PCT_W-1:0]    direct_pct;
  logic                need_div;

  always_comb begin
    seg_hit  = 1'b0;
    seg_base = PCT_ZERO;
    seg_lo   = brk_r[0];
    seg_hi   = brk_r[1];
    // Walk downward so the lowest matching segment wins
    for (int i = NUM_BREAKS - 2; i >= 0; i--) begin
      if ((last_mean_r >= brk_r[i]) && (last_mean_r < brk_r[i+1])) begin
        seg_hit  = 1'b1;
        seg_base = PCT_W'(i * 20);
        seg_lo   = brk_r[i];
        seg_hi   = brk_r[i+1];
      end
    end
  end

  always_comb begin
    need_div   = 1'b0;
    direct_pct = PCT_FULL;
    if (last_mean_r < brk_r[0]) begin
      direct_pct = PCT_ZERO;
    end else if (last_mean_r >= brk_r[NUM_BREAKS-1]) begin
      direct_pct = PCT_FULL;
    end else if (seg_hit) begin
      need_div = 1'b1;
    end
  end

  assign seg_diff     = last_mean_r - seg_lo;
  assign seg_num      = NUM_W'({seg_diff, 4'b0000}) + NUM_W'({seg_diff, 2'b00});
  assign sts.need_div = need_div;

  // Shared restoring divider, one quotient bit per cycle
  logic [DIV_W-1:0] div_quo_r;
  logic [DVS_W-1:0] div_rem_r;
  logic [DVS_W-1:0] div_dvs_r;
  logic [DC_W-1:0]  div_cnt_r;
  logic [DVS_W:0]   div_sh;
  logic [DVS_W:0]   div_diff;
  logic             div_ge;
  logic             div_start;
  logic [PCT_W-1:0] base_r;

  assign div_sh       = {div_rem_r, div_quo_r[DIV_W-1]};
  assign div_diff     = div_sh - {1'b0, div_dvs_r};
  assign div_ge       = (div_sh >= {1'b0, div_dvs_r});
  assign div_start    = cmd.div_start_mean || (cmd.map_run && need_div);
  assign sts.div_done = (div_cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (div_start) begin
      div_cnt_r <= DC_W'(DIV_W);
    end else if (cmd.div_run && !sts.div_done) begin
      div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start_mean) begin
      div_quo_r <= DIV_W'(sum_r);
      div_dvs_r <= DVS_W'(fill_r);
      div_rem_r <= '0;
    end else if (cmd.map_run && need_div) begin
      div_quo_r <= DIV_W'(seg_num);
      div_dvs_r <= seg_hi - seg_lo;
      div_rem_r <= '0;
      base_r    <= seg_base;
    end else if (cmd.div_run && !sts.div_done) begin
      div_rem_r <= div_ge ? div_diff[DVS_W-1:0] : div_sh[DVS_W-1:0];
      div_quo_r <= {div_quo_r[DIV_W-2:0], div_ge};
    end
  end

  // Held level and mean
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_mean_r <= MEAN_RESET;
      last_pct_r  <= PCT_FULL;
    end else begin
      if (cmd.commit_mean) begin
        last_mean_r <= div_quo_r[SAMPLE_W-1:0];
      end
      if (cmd.map_run && !need_div) begin
        last_pct_r <= direct_pct;
      end else if (cmd.commit_pct) begin
        last_pct_r <= base_r + div_quo_r[PCT_W-1:0];
      end
    end
  end

  // Charging flag and output register
  logic                charging_r;
  logic [PCT_W-1:0]    out_pct_r;
  logic [SAMPLE_W-1:0] out_mean_r;
  logic                out_chg_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      charging_r <= in_charge_pin;
    end
    if (cmd.out_load) begin
      out_pct_r  <= last_pct_r;
      out_mean_r <= last_mean_r;
      out_chg_r  <= charging_r;
    end
  end

  assign out_percent     = out_pct_r;
  assign out_mean_sample = out_mean_r;
  assign out_charging    = out_chg_r;

endmodule
`default_nettype wire

FILE: hw/rtl/battery_gauge_average_interpolate.sv
// Top level of the battery gauge: averaging and piecewise-linear level mapping.
`default_nettype none
// Each request is one tick: a 12-bit ADC sample, a flag that says whether the
// read succeeded, and the charger pin. Every request yields exactly one result
// with the battery percentage, the mean sample and the charging flag. A valid
// sample is pushed into a ring of the last HISTORY_DEPTH samples; the filled
// entries are summed one per cycle and divided by the fill count, and the mean
// is mapped through six breakpoints (0, 20, ..., 100 percent) with a truncated
// interpolation quotient. An invalid sample leaves mean and level as they were
// and its result goes directly to the output register stage once the request
// is taken. A valid sample is handled in order by summing the ring, a pass of
// the shared one-bit-per-cycle divider for the mean (17 quotient bits), the
// segment search, a second divider pass for the interpolation step when the
// mean falls inside a segment (skipped when the mean clamps at either end),
// and the load of the output register. A result also waits while the previous
// one is still held by out_stall. One request is in flight at a time and the
// next one is taken from the cycle after the result is loaded; a finished
// result sits in the output register, so the next request is taken while the
// previous result still waits on out_stall. Breakpoints are to be written
// through the cfg port at indexes 0 to 5 only while the block is idle; the
// block itself does not enforce this. Indexes beyond that are ignored.
module battery_gauge_average_interpolate
  import bgai_pkg::*;
#(
  parameter int HISTORY_DEPTH = 3
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [SAMPLE_W-1:0]  in_sample,
  input  wire logic                 in_sample_valid,
  input  wire logic                 in_charge_pin,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [PCT_W-1:0]          out_percent,
  output logic [SAMPLE_W-1:0]       out_mean_sample,
  output logic                      out_charging,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SAMPLE_W-1:0]  cfg_wdata
);

  bgai_cmd_t cmd;
  bgai_sts_t sts;

  // Sequence each valid request through sum, mean divide, map and, when needed, level divide
  bgai_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_sample_valid (in_sample_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .sts             (sts),
    .cmd             (cmd)
  );

  // Hold the ring, the breakpoints, the divider and the output register
  bgai_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_sample       (in_sample),
    .in_sample_valid (in_sample_valid),
    .in_charge_pin   (in_charge_pin),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_percent     (out_percent),
    .out_mean_sample (out_mean_sample),
    .out_charging    (out_charging)
  );

  // A taken request makes the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken but block not busy");

  // The level never exceeds full scale
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_percent <= PCT_FULL))
    else $error("percent above full scale");

  // The shared divider is only started when it is free
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_start_mean || (cmd.map_run && sts.need_div)) |-> sts.div_done)
    else $error("divider restarted while busy");

endmodule
`default_nettype wire

FILE: tb/sv/battery_gauge_average_interpolate_test.sv
// Self-checking testbench of the battery gauge: directed plan, random ticks, breakpoint sweeps.
`timescale 1ns / 1ps
module battery_gauge_average_interpolate_test;
  import bgai_pkg::*;

  // Ring depth of the block as instantiated (its default).
  localparam int HIST_DEPTH = 3;
  localparam int RAND_PER_PHASE = 116;
  localparam int NUM_SETTINGS = 8;
  localparam int IDLE_PCT = 13;
  localparam int DRAIN_CYCLES = 64;

  // Register indexes: the six breakpoints, then two unused slots that must be ignored.
  localparam logic [CFG_IDX_W-1:0] IDX_BRK_FIRST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] IDX_BRK_LAST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [PCT_W-1:0] percent;
    logic [SAMPLE_W-1:0] mean;
    logic charging;
  } gauge_t;

  // One row of the directed plan; typed rows carry their expected level and mean.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic sample_valid;
    logic charge_pin;
    logic typed;
    logic [PCT_W-1:0] percent;
    logic [SAMPLE_W-1:0] mean;
  } plan_row_t;

  localparam int PLAN_LEN = 23;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // nothing stored yet: hold the reset level and mean
    '{12'd0, 1'b0, 1'b0, 1'b1, PCT_FULL, MEAN_RESET},
    '{12'd4095, 1'b0, 1'b1, 1'b1, PCT_FULL, MEAN_RESET},
    // first sample of zero sits below every breakpoint
    '{12'd0, 1'b1, 1'b1, 1'b1, PCT_ZERO, 12'd0},
    '{12'd4095, 1'b1, 1'b0, 1'b0, PCT_ZERO, 12'd0},
    '{12'd4095, 1'b1, 1'b1, 1'b0, PCT_ZERO, 12'd0},
    // invalid read holds whatever was there
    '{12'd123, 1'b0, 1'b1, 1'b0, PCT_ZERO, 12'd0},
    // just below the first breakpoint
    '{12'd1969, 1'b1, 1'b0, 1'b0, PCT_ZERO, 12'd0},
    '{12'd1969, 1'b1, 1'b0, 1'b0, PCT_ZERO, 12'd0},
    '{12'd1969, 1'b1, 1'b1, 1'b0, PCT_ZERO, 12'd0},
    // exactly on the first breakpoint
    '{12'd1970, 1'b1, 1'b0, 1'b0, PCT_ZERO, 12'd0},
    '{12'd1970, 1'b1, 1'b0, 1'b0, PCT_ZERO, 12'd0},
    '{12'd1970, 1'b1, 1'b1, 1'b0, PCT_ZERO, 12'd0},
    // exactly on the last breakpoint
    '{12'd2430, 1'b1, 1'b0, 1'b0, PCT_ZERO, 12'd0},
    '{12'd2430, 1'b1, 1'b1, 1'b0, PCT_ZERO, 12'd0},
    '{12'd2430, 1'b1, 1'b0, 1'b0, PCT_ZERO, 12'd0},
    '{12'd0, 1'b0, 1'b0, 1'b0, PCT_ZERO, 12'd0},
    // one below the last breakpoint
    '{12'd2429, 1'b1, 1'b1, 1'b0, PCT_ZERO, 12'd0},
    '{12'd2429, 1'b1, 1'b0, 1'b0, PCT_ZERO, 12'd0},
    '{12'd2429, 1'b1, 1'b1, 1'b0, PCT_ZERO, 12'd0},
    // middle of an inner segment
    '{12'd2200, 1'b1, 1'b0, 1'b0, PCT_ZERO, 12'd0},
    '{12'd2200, 1'b1, 1'b1, 1'b0, PCT_ZERO, 12'd0},
    '{12'd2200, 1'b1, 1'b0, 1'b0, PCT_ZERO, 12'd0},
    '{12'd2200, 1'b0, 1'b1, 1'b0, PCT_ZERO, 12'd0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [SAMPLE_W-1:0] in_sample;
  logic in_sample_valid;
  logic in_charge_pin;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PCT_W-1:0] out_percent;
  logic [SAMPLE_W-1:0] out_mean_sample;
  logic out_charging;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SAMPLE_W-1:0] cfg_wdata;

  // Shadow state of the gauge, advanced once per accepted request.
  brk_arr_t brk;
  logic [SAMPLE_W-1:0] hist [HIST_DEPTH];
  int unsigned hist_slot;
  int unsigned hist_fill;
  logic [PCT_W-1:0] held_pct;
  logic [SAMPLE_W-1:0] held_mean;

  // Results still owed by the block, oldest first.
  gauge_t level_q [$];

  bit calm = 1'b0;
  int errors = 0;
  int ticks_sent = 0;
  int samples_taken = 0;
  int results_seen = 0;
  int settings_used = 0;

  battery_gauge_average_interpolate i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_sample_valid (in_sample_valid),
    .in_charge_pin   (in_charge_pin),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_percent     (out_percent),
    .out_mean_sample (out_mean_sample),
    .out_charging    (out_charging),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Map a mean to a level: clamp at both ends, else take the first segment that holds it.
  function automatic logic [PCT_W-1:0] map_level(input logic [SAMPLE_W-1:0] v);
    int unsigned lo;
    int unsigned hi;
    if (v < brk[0]) return PCT_ZERO;
    if (v >= brk[NUM_BREAKS-1]) return PCT_FULL;
    for (int i = 0; i < NUM_BREAKS - 1; i++) begin
      lo = brk[i];
      hi = brk[i+1];
      if (v >= lo && v < hi) begin
        return PCT_W'(i * int'(STEP_PCT) + ((v - lo) * int'(STEP_PCT)) / (hi - lo));
      end
    end
    return PCT_FULL;
  endfunction

  // Advance the shadow gauge by one tick and return the result it should produce.
  function automatic gauge_t gauge_tick(input logic [SAMPLE_W-1:0] s, input logic sv,
                                        input logic cp);
    gauge_t r;
    int unsigned sum;
    if (sv) begin
      hist[hist_slot] = s;
      hist_slot = (hist_slot + 1) % HIST_DEPTH;
      if (hist_fill < HIST_DEPTH) hist_fill++;
      sum = 0;
      for (int i = 0; i < hist_fill; i++) sum += hist[i];
      held_mean = SAMPLE_W'(sum / hist_fill);
      held_pct = map_level(held_mean);
    end
    r.percent = held_pct;
    r.mean = held_mean;
    r.charging = cp;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [SAMPLE_W-1:0] got,
                                 input logic [SAMPLE_W-1:0] want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    errors++;
  endtask

  // Offer one request, hold it until the block takes it, then queue what it owes.
  task automatic push_tick(input logic [SAMPLE_W-1:0] s, input logic sv, input logic cp,
                           input logic typed, input gauge_t want);
    gauge_t pred;
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_sample = s;
    in_sample_valid = sv;
    in_charge_pin = cp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = gauge_tick(s, sv, cp);
    level_q.push_back(typed ? want : pred);
    ticks_sent++;
    if (sv) samples_taken++;
  endtask

  // Drop valid and wait until every owed result has left the block.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (level_q.size() != 0) @(negedge clk);
  endtask

  // Write all six breakpoints plus the two unused indexes, one write per cycle.
  task automatic load_breaks(input brk_arr_t vals);
    for (int i = IDX_BRK_FIRST; i <= IDX_BRK_LAST; i++) begin
      @(negedge clk);
      cfg_we = 1'b1;
      cfg_index = CFG_IDX_W'(i);
      cfg_wdata = vals[i];
      brk[i] = vals[i];
    end
    for (int i = IDX_SPARE_LO; i <= IDX_SPARE_HI; i++) begin
      @(negedge clk);
      cfg_we = 1'b1;
      cfg_index = CFG_IDX_W'(i);
      cfg_wdata = SAMPLE_W'($urandom);
    end
    @(negedge clk);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  // Bias samples toward the breakpoints and the ends of the range.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(9))
      0: v = 0;
      1: v = (1 << SAMPLE_W) - 1;
      2, 3, 4, 5: begin
        v = int'(brk[$urandom_range(NUM_BREAKS - 1)]) + int'($urandom_range(8)) - 4;
        if (v < 0) v = 0;
        if (v > (1 << SAMPLE_W) - 1) v = (1 << SAMPLE_W) - 1;
      end
      default: v = $urandom_range((1 << SAMPLE_W) - 1);
    endcase
    return SAMPLE_W'(v);
  endfunction

  // Build breakpoint setting n: defaults, flat ends, full spread, random, unordered, reversed.
  function automatic brk_arr_t make_setting(input int n);
    brk_arr_t b;
    case (n)
      1: foreach (b[i]) b[i] = '0;
      2: foreach (b[i]) b[i] = '1;
      3: foreach (b[i]) b[i] = SAMPLE_W'(i * 819);
      4: begin
        b[0] = SAMPLE_W'($urandom_range(2000));
        for (int i = 1; i < NUM_BREAKS; i++) b[i] = b[i-1] + SAMPLE_W'($urandom_range(400));
      end
      5: begin
        foreach (b[i]) b[i] = SAMPLE_W'($urandom);
        b[3] = b[2];
      end
      6: foreach (b[i]) b[i] = SAMPLE_W'(4095 - i * 819);
      default: b = BREAK_RESET;
    endcase
    return b;
  endfunction

  // Receiver: stall at random except in the calm stretch.
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Check every result taken against the oldest one owed.
  always @(posedge clk) begin : check_results
    gauge_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall == 1'b0) begin
      results_seen++;
      if (level_q.size() == 0) begin
        $display("[%0t] result with nothing owed: percent %0d mean %0d", $time,
                 out_percent, out_mean_sample);
        errors++;
      end else begin
        want = level_q.pop_front();
        if (out_percent !== want.percent)
          report_mismatch("percent", SAMPLE_W'(out_percent), SAMPLE_W'(want.percent));
        if (out_mean_sample !== want.mean)
          report_mismatch("mean_sample", out_mean_sample, want.mean);
        if (out_charging !== want.charging)
          report_mismatch("charging", SAMPLE_W'(out_charging), SAMPLE_W'(want.charging));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results still owed", level_q.size());
    $display("battery_gauge_average_interpolate_test: FAIL");
    $finish;
  end

  initial begin : stimulus
    gauge_t want;
    logic sv;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    in_sample_valid = 1'b0;
    in_charge_pin = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    // Reset the shadow gauge to the block's reset state.
    brk = BREAK_RESET;
    foreach (hist[i]) hist[i] = '0;
    hist_slot = 0;
    hist_fill = 0;
    held_pct = PCT_FULL;
    held_mean = MEAN_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    settings_used = 1;

    // Walk the directed plan on the reset breakpoints.
    foreach (PLAN[r]) begin
      want.percent = PLAN[r].percent;
      want.mean = PLAN[r].mean;
      want.charging = PLAN[r].charge_pin;
      push_tick(PLAN[r].sample, PLAN[r].sample_valid, PLAN[r].charge_pin, PLAN[r].typed, want);
    end

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      // Reprogram only once the block has gone idle.
      if (p > 0) begin
        settle();
        load_breaks(make_setting(p));
      end
      calm = (p == 3);
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        // Hold off the sender once mid-run until everything owed has drained.
        if (p == 5 && k == RAND_PER_PHASE / 2) settle();
        sv = ($urandom_range(99) >= 15);
        push_tick(pick_sample(), sv, 1'($urandom), 1'b0, want);
      end
      calm = 1'b0;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d ticks (%0d valid samples) over %0d breakpoint settings", ticks_sent,
             samples_taken, settings_used);
    $display("checked %0d results, %0d mismatches", results_seen, errors);
    if (errors == 0 && level_q.size() == 0) begin
      $display("battery_gauge_average_interpolate_test: PASS");
    end else begin
      $display("battery_gauge_average_interpolate_test: FAIL");
    end
    $finish;
  end

endmodule
